[hdl/qftv_pkg.sv]
`default_nettype none
package qftv_pkg;

  // fixed formats
  localparam int VEC_W     = 16;
  localparam int FRAC_BITS = 14;
  localparam int OUT_W     = 16;
  localparam int CFG_W     = 32;
  localparam int RND_SH    = 30 - FRAC_BITS;
  localparam logic [31:0] RND_HALF = 32'd1 << (RND_SH - 1);
  localparam logic signed [OUT_W-1:0] W_ONE = OUT_W'(1 << FRAC_BITS);

  // input word: source and target vectors
  typedef struct packed {
    logic signed [VEC_W-1:0] first_x;
    logic signed [VEC_W-1:0] first_y;
    logic signed [VEC_W-1:0] first_z;
    logic signed [VEC_W-1:0] second_x;
    logic signed [VEC_W-1:0] second_y;
    logic signed [VEC_W-1:0] second_z;
  } in_word_t;

  // result word: quaternion and flag
  typedef struct packed {
    logic signed [OUT_W-1:0] quat_w;
    logic signed [OUT_W-1:0] quat_x;
    logic signed [OUT_W-1:0] quat_y;
    logic signed [OUT_W-1:0] quat_z;
    logic                    degenerate;
  } out_word_t;

  typedef logic [2:0][30:0] ct_arr_t;

  // sideband into the cross length root
  typedef struct packed {
    logic [2:0][31:0] cm;
    logic [2:0]       cneg;
    logic             dneg;
    logic [31:0]      dmag;
  } tag_l_t;

  // sideband into the angle norm root
  typedef struct packed {
    logic        degen;
    logic        dneg;
    logic [2:0]  cneg;
    logic [29:0] cp;
    logic [29:0] dp;
    logic [30:0] lt;
    ct_arr_t     ct;
  } tag_p_t;

  // sideband riding with the cosine divider
  typedef struct packed {
    logic        degen;
    logic        dneg;
    logic [2:0]  cneg;
    logic [30:0] lt;
  } tag_ca_t;

  // sideband into the half angle root
  typedef struct packed {
    logic        degen;
    logic        dneg;
    logic [2:0]  cneg;
    logic [30:0] lt;
    ct_arr_t     ct;
    logic [30:0] si;
  } tag_b_t;

  // sideband into the half angle sine divider
  typedef struct packed {
    logic        degen;
    logic        dneg;
    logic [2:0]  cneg;
    logic [30:0] lt;
    ct_arr_t     ct;
    logic [30:0] big;
  } tag_s_t;

  // sideband with the first axis divider
  typedef struct packed {
    logic        degen;
    logic        neg;
    logic [30:0] cw;
  } tag_m_t;

  // q30 magnitude to rounded, signed, saturated output
  function automatic logic signed [OUT_W-1:0] frac_pack(input logic [30:0] q, input logic neg);
    logic [31:0] r;
    logic [16:0] m;
    r = ({1'b0, q} + RND_HALF) >> RND_SH;
    m = r[16:0];
    if (!neg) begin
      return (m > 17'd32767) ? 16'sh7fff : OUT_W'(m);
    end
    return (m > 17'd32768) ? 16'sh8000 : OUT_W'(17'd0 - m);
  endfunction

endpackage
`default_nettype wire

[hdl/qftv_sqrt.sv]
`default_nettype none
module qftv_sqrt #(
  parameter int OUT_W = 32,
  parameter int TAG_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_vld,
  input  logic [2*OUT_W-1:0] rad_in,
  input  logic [TAG_W-1:0]   tag_in,
  output logic               out_vld,
  output logic [OUT_W-1:0]   root_out,
  output logic [TAG_W-1:0]   tag_out
);
  localparam int IN_W  = 2 * OUT_W;
  localparam int REM_W = OUT_W + 1;

  logic [REM_W-1:0] rem  [OUT_W+1];
  logic [OUT_W-1:0] root [OUT_W+1];
  logic [IN_W-1:0]  rad  [OUT_W+1];
  logic [TAG_W-1:0] tag  [OUT_W+1];
  logic             vld  [OUT_W+1];

  // stage zero is the input
  assign rem[0]  = '0;
  assign root[0] = '0;
  assign rad[0]  = rad_in;
  assign tag[0]  = tag_in;
  assign vld[0]  = in_vld;

  // one root bit per stage
  for (genvar k = 0; k < OUT_W; k++) begin : g_stage
    logic [REM_W+1:0] rs;
    logic [REM_W+1:0] trial;
    logic             ge;

    always_comb begin
      rs    = {rem[k], rad[k][IN_W-1 -: 2]};
      trial = {1'b0, root[k], 2'b01};
      ge    = rs >= trial;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1]  <= ge ? REM_W'(rs - trial) : rs[REM_W-1:0];
      root[k+1] <= {root[k][OUT_W-2:0], ge};
      rad[k+1]  <= {rad[k][IN_W-3:0], 2'b00};
      tag[k+1]  <= tag[k];
    end
  end

  assign out_vld  = vld[OUT_W];
  assign root_out = root[OUT_W];
  assign tag_out  = tag[OUT_W];
endmodule
`default_nettype wire

[hdl/qftv_div.sv]
`default_nettype none
module qftv_div #(
  parameter int NUM_W = 60,
  parameter int DEN_W = 31,
  parameter int Q_W   = 31,
  parameter int TAG_W = 1
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_vld,
  input  logic [NUM_W-1:0] num_in,
  input  logic [DEN_W-1:0] den_in,
  input  logic [TAG_W-1:0] tag_in,
  output logic             out_vld,
  output logic [Q_W-1:0]   quo_out,
  output logic [TAG_W-1:0] tag_out
);
  logic [DEN_W-1:0] rem [Q_W+1];
  logic [DEN_W-1:0] den [Q_W+1];
  logic [Q_W-1:0]   lo  [Q_W+1];
  logic [Q_W-1:0]   quo [Q_W+1];
  logic [TAG_W-1:0] tag [Q_W+1];
  logic             vld [Q_W+1];

  // upper numerator bits seed the remainder, quotient fits q_w bits
  assign rem[0] = DEN_W'(num_in[NUM_W-1:Q_W]);
  assign den[0] = den_in;
  assign lo[0]  = num_in[Q_W-1:0];
  assign quo[0] = '0;
  assign tag[0] = tag_in;
  assign vld[0] = in_vld;

  // restoring step, one quotient bit per stage
  for (genvar k = 0; k < Q_W; k++) begin : g_stage
    logic [DEN_W:0] rs;
    logic [DEN_W:0] dx;
    logic           ge;

    always_comb begin
      rs = {rem[k], lo[k][Q_W-1]};
      dx = {1'b0, den[k]};
      ge = rs >= dx;
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else begin
        vld[k+1] <= vld[k];
      end
    end

    always_ff @(posedge clk) begin
      rem[k+1] <= ge ? DEN_W'(rs - dx) : rs[DEN_W-1:0];
      den[k+1] <= den[k];
      lo[k+1]  <= {lo[k][Q_W-2:0], 1'b0};
      quo[k+1] <= {quo[k][Q_W-2:0], ge};
      tag[k+1] <= tag[k];
    end
  end

  assign out_vld = vld[Q_W];
  assign quo_out = quo[Q_W];
  assign tag_out = tag[Q_W];
endmodule
`default_nettype wire

[hdl/quaternion_from_two_vectors.sv]
// start to done runs through registered stages and the chain of bit-per-stage
//   square roots (32 + 31 + 31 stages) and dividers (3 x 31 stages)
// throughput: one word per cycle; busy stays low, done pulses once per word
// the receiver cannot stall; results are never held back
// reset: synchronous, clears all valid bits and min_cross_length to zero
`default_nettype none
module quaternion_from_two_vectors (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  qftv_pkg::in_word_t     operands,
  output logic                   done,
  output qftv_pkg::out_word_t    result,
  input  logic                   cfg_we,
  input  logic [qftv_pkg::CFG_W-1:0] cfg_wdata
);
  import qftv_pkg::*;

  logic [CFG_W-1:0] min_cross_length;

  // threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      min_cross_length <= '0;
    end else if (cfg_we) begin
      min_cross_length <= cfg_wdata;
    end
  end

  assign busy = 1'b0;

  // stage 1: component products
  logic               s1_vld;
  logic signed [31:0] s1_c0a, s1_c0b, s1_c1a, s1_c1b, s1_c2a, s1_c2b;
  logic signed [31:0] s1_d0, s1_d1, s1_d2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_vld <= 1'b0;
    end else begin
      s1_vld <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_c0a <= operands.first_y * operands.second_z;
    s1_c0b <= operands.first_z * operands.second_y;
    s1_c1a <= operands.first_z * operands.second_x;
    s1_c1b <= operands.first_x * operands.second_z;
    s1_c2a <= operands.first_x * operands.second_y;
    s1_c2b <= operands.first_y * operands.second_x;
    s1_d0  <= operands.first_x * operands.second_x;
    s1_d1  <= operands.first_y * operands.second_y;
    s1_d2  <= operands.first_z * operands.second_z;
  end

  // stage 2: cross and dot
  logic               s2_vld;
  logic signed [32:0] s2_c [3];
  logic signed [33:0] s2_d;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_vld <= 1'b0;
    end else begin
      s2_vld <= s1_vld;
    end
  end

  always_ff @(posedge clk) begin
    s2_c[0] <= 33'(s1_c0a) - 33'(s1_c0b);
    s2_c[1] <= 33'(s1_c1a) - 33'(s1_c1b);
    s2_c[2] <= 33'(s1_c2a) - 33'(s1_c2b);
    s2_d    <= 34'(s1_d0) + 34'(s1_d1) + 34'(s1_d2);
  end

  // stage 3: magnitudes and signs
  logic   s3_vld;
  tag_l_t s3_tag;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_vld <= 1'b0;
    end else begin
      s3_vld <= s2_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      s3_tag.cm[i]   <= s2_c[i][32] ? 32'(-s2_c[i]) : 32'(s2_c[i]);
      s3_tag.cneg[i] <= s2_c[i][32];
    end
    s3_tag.dneg <= s2_d[33];
    s3_tag.dmag <= s2_d[33] ? 32'(-s2_d) : 32'(s2_d);
  end

  // stage 4: squares of the cross terms
  logic        s4_vld;
  tag_l_t      s4_tag;
  logic [63:0] s4_sq [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_vld <= 1'b0;
    end else begin
      s4_vld <= s3_vld;
    end
  end

  always_ff @(posedge clk) begin
    s4_tag <= s3_tag;
    for (int i = 0; i < 3; i++) begin
      s4_sq[i] <= 64'(s3_tag.cm[i]) * 64'(s3_tag.cm[i]);
    end
  end

  // stage 5: squared cross length
  logic        s5_vld;
  tag_l_t      s5_tag;
  logic [63:0] s5_c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s5_vld <= 1'b0;
    end else begin
      s5_vld <= s4_vld;
    end
  end

  always_ff @(posedge clk) begin
    s5_tag <= s4_tag;
    s5_c2  <= s4_sq[0] + s4_sq[1] + s4_sq[2];
  end

  // cross length root
  logic        l_vld;
  logic [31:0] l_root;
  tag_l_t      l_tag;

  qftv_sqrt #(.OUT_W(32), .TAG_W($bits(tag_l_t))) u_sqrt_l (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (s5_vld),
    .rad_in  (s5_c2),
    .tag_in  (s5_tag),
    .out_vld (l_vld),
    .root_out(l_root),
    .tag_out (l_tag)
  );

  // stage a: threshold, block scaling, axis scaling
  logic        a_vld;
  tag_p_t      a_tag;
  logic [31:0] a_lsh, a_dsh, a_lt;
  logic        a_t;

  always_comb begin
    if (l_root[31] || l_tag.dmag[31]) begin
      a_lsh = l_root >> 2;
      a_dsh = l_tag.dmag >> 2;
    end else if (l_root[30] || l_tag.dmag[30]) begin
      a_lsh = l_root >> 1;
      a_dsh = l_tag.dmag >> 1;
    end else begin
      a_lsh = l_root;
      a_dsh = l_tag.dmag;
    end
    a_t  = l_root[31];
    a_lt = a_t ? (l_root >> 1) : l_root;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_vld <= 1'b0;
    end else begin
      a_vld <= l_vld;
    end
  end

  always_ff @(posedge clk) begin
    a_tag.degen <= l_root <= min_cross_length;
    a_tag.dneg  <= l_tag.dneg;
    a_tag.cneg  <= l_tag.cneg;
    a_tag.cp    <= a_lsh[29:0];
    a_tag.dp    <= a_dsh[29:0];
    a_tag.lt    <= a_lt[30:0];
    for (int i = 0; i < 3; i++) begin
      a_tag.ct[i] <= a_t ? l_tag.cm[i][31:1] : l_tag.cm[i][30:0];
    end
  end

  // stage b: squares of the scaled terms
  logic        b_vld;
  tag_p_t      b_tag;
  logic [59:0] b_cc, b_dd;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
    end else begin
      b_vld <= a_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_tag <= a_tag;
    b_cc  <= 60'(a_tag.cp) * 60'(a_tag.cp);
    b_dd  <= 60'(a_tag.dp) * 60'(a_tag.dp);
  end

  // stage c: norm squared
  logic        c_vld;
  tag_p_t      c_tag;
  logic [60:0] c_sum;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_vld <= 1'b0;
    end else begin
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    c_tag <= b_tag;
    c_sum <= 61'(b_cc) + 61'(b_dd);
  end

  // norm root
  logic        p_vld;
  logic [30:0] p_root, p_den;
  tag_p_t      p_tag;

  qftv_sqrt #(.OUT_W(31), .TAG_W($bits(tag_p_t))) u_sqrt_p (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (c_vld),
    .rad_in  ({1'b0, c_sum}),
    .tag_in  (c_tag),
    .out_vld (p_vld),
    .root_out(p_root),
    .tag_out (p_tag)
  );

  assign p_den = (p_root == '0) ? 31'd1 : p_root;

  // cosine and sine of the full angle
  tag_ca_t     ca_in, ca_tag;
  logic        ca_vld, cb_vld;
  logic [30:0] co, si;
  ct_arr_t     cb_ct;

  always_comb begin
    ca_in.degen = p_tag.degen;
    ca_in.dneg  = p_tag.dneg;
    ca_in.cneg  = p_tag.cneg;
    ca_in.lt    = p_tag.lt;
  end

  qftv_div #(.NUM_W(60), .DEN_W(31), .Q_W(31), .TAG_W($bits(tag_ca_t))) u_div_co (
    .clk    (clk),
    .rst    (rst),
    .in_vld (p_vld),
    .num_in ({p_tag.dp, 30'd0}),
    .den_in (p_den),
    .tag_in (ca_in),
    .out_vld(ca_vld),
    .quo_out(co),
    .tag_out(ca_tag)
  );

  qftv_div #(.NUM_W(60), .DEN_W(31), .Q_W(31), .TAG_W($bits(ct_arr_t))) u_div_si (
    .clk    (clk),
    .rst    (rst),
    .in_vld (p_vld),
    .num_in ({p_tag.cp, 30'd0}),
    .den_in (p_den),
    .tag_in (p_tag.ct),
    .out_vld(cb_vld),
    .quo_out(si),
    .tag_out(cb_ct)
  );

  // half angle cosine root
  tag_b_t      hb_in, hb_tag;
  logic [31:0] hb_arg;
  logic        hb_vld;
  logic [30:0] big;

  always_comb begin
    hb_arg      = 32'h4000_0000 + {1'b0, co};
    hb_in.degen = ca_tag.degen;
    hb_in.dneg  = ca_tag.dneg;
    hb_in.cneg  = ca_tag.cneg;
    hb_in.lt    = ca_tag.lt;
    hb_in.ct    = cb_ct;
    hb_in.si    = si;
  end

  qftv_sqrt #(.OUT_W(31), .TAG_W($bits(tag_b_t))) u_sqrt_big (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (ca_vld & cb_vld),
    .rad_in  ({1'b0, hb_arg, 29'd0}),
    .tag_in  (hb_in),
    .out_vld (hb_vld),
    .root_out(big),
    .tag_out (hb_tag)
  );

  // half angle sine divide
  tag_s_t      hs_in, hs_tag;
  logic        hs_vld;
  logic [30:0] sml;

  always_comb begin
    hs_in.degen = hb_tag.degen;
    hs_in.dneg  = hb_tag.dneg;
    hs_in.cneg  = hb_tag.cneg;
    hs_in.lt    = hb_tag.lt;
    hs_in.ct    = hb_tag.ct;
    hs_in.big   = big;
  end

  qftv_div #(.NUM_W(60), .DEN_W(31), .Q_W(31), .TAG_W($bits(tag_s_t))) u_div_sml (
    .clk    (clk),
    .rst    (rst),
    .in_vld (hb_vld),
    .num_in ({hb_tag.si, 29'd0}),
    .den_in (big),
    .tag_in (hs_in),
    .out_vld(hs_vld),
    .quo_out(sml),
    .tag_out(hs_tag)
  );

  // stage d: pick half angle terms, scale the axis
  logic        d_vld;
  logic [61:0] d_prod [3];
  logic [30:0] d_lt;
  tag_m_t      d_m0;
  logic [1:0]  d_neg12;
  logic [30:0] d_sw;

  assign d_sw = hs_tag.dneg ? hs_tag.big : sml;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_vld <= 1'b0;
    end else begin
      d_vld <= hs_vld;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      d_prod[i] <= 62'(d_sw) * 62'(hs_tag.ct[i]);
    end
    d_lt       <= hs_tag.lt;
    d_m0.degen <= hs_tag.degen;
    d_m0.neg   <= hs_tag.cneg[0];
    d_m0.cw    <= hs_tag.dneg ? sml : hs_tag.big;
    d_neg12    <= hs_tag.cneg[2:1];
  end

  // axis divides
  logic        m_vld, m1_vld, m2_vld;
  logic [30:0] mq0, mq1, mq2;
  tag_m_t      m_tag;
  logic        m_neg1, m_neg2;

  qftv_div #(.NUM_W(62), .DEN_W(31), .Q_W(31), .TAG_W($bits(tag_m_t))) u_div_mx (
    .clk    (clk),
    .rst    (rst),
    .in_vld (d_vld),
    .num_in (d_prod[0]),
    .den_in (d_lt),
    .tag_in (d_m0),
    .out_vld(m_vld),
    .quo_out(mq0),
    .tag_out(m_tag)
  );

  qftv_div #(.NUM_W(62), .DEN_W(31), .Q_W(31), .TAG_W(1)) u_div_my (
    .clk    (clk),
    .rst    (rst),
    .in_vld (d_vld),
    .num_in (d_prod[1]),
    .den_in (d_lt),
    .tag_in (d_neg12[0]),
    .out_vld(m1_vld),
    .quo_out(mq1),
    .tag_out(m_neg1)
  );

  qftv_div #(.NUM_W(62), .DEN_W(31), .Q_W(31), .TAG_W(1)) u_div_mz (
    .clk    (clk),
    .rst    (rst),
    .in_vld (d_vld),
    .num_in (d_prod[2]),
    .den_in (d_lt),
    .tag_in (d_neg12[1]),
    .out_vld(m2_vld),
    .quo_out(mq2),
    .tag_out(m_neg2)
  );

  // stage e: round, saturate, output word
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= m_vld & m1_vld & m2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (m_tag.degen) begin
      result.quat_w <= W_ONE;
      result.quat_x <= '0;
      result.quat_y <= '0;
      result.quat_z <= '0;
    end else begin
      result.quat_w <= frac_pack(m_tag.cw, 1'b0);
      result.quat_x <= frac_pack(mq0, m_tag.neg);
      result.quat_y <= frac_pack(mq1, m_neg1);
      result.quat_z <= frac_pack(mq2, m_neg2);
    end
    result.degenerate <= m_tag.degen;
  end

endmodule
`default_nettype wire
